/* hdl/ffla_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffla_pkg - shared types and constants of the first-fit free-list allocator
// Holds register indexes, operation codes, the sequencer state type and the
// control bundle broadcast to the entry cells.
// ----------------------------------------------------------------------------
package ffla_pkg;

    localparam int unsigned FFLA_MAX_ENTRIES = 1024;
    localparam int unsigned CFG_IDX_W        = 2;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_END  = CFG_IDX_W'(1);

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REST
    } st_t;

    // per-cycle command to every cell of the ring
    typedef struct packed {
        logic        rot;     // rotate ring one place toward cell 0
        logic        shl;     // close gap at cell 0 (cells below lim take right)
        logic        shr;     // open gap at cell 0 (cells 1..lim take left)
        logic        wr0;     // load cell 0 from wstart/wlen
        logic        wrl;     // load last cell from wstart/wlen
        logic [31:0] wstart;
        logic [31:0] wlen;
    } cell_ctl_t;

endpackage
`default_nettype wire

/* hdl/first_fit_free_list_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator - first-fit allocator with coalescing release
// Address-sorted free list kept in a ring of entry cells; a sequencer walks
// the ring once per item, edits the entry at the ring head and rotates back.
// ----------------------------------------------------------------------------
//  channel | ports            | payload
//  --------+------------------+-------------------------------------------------
//  input   | s_tvalid/tready  | tuser: func; tdata: block_addr, block_len
//  result  | m_tvalid/tready  | tdata: grant_addr, grant_ok, free_total,
//          |                  |        entry_count, lost_blocks, lost_bytes
//  config  | cfg_we           | cfg_index, cfg_data (heap_base, heap_end)
//
// an item is accepted, then the ring rotates through a full turn with one edit
// step at the ring head along the way, and the result is handed over; the
// full-ring rotation dominates the time that an item takes
// reset loads the single entry (0, 0) into the head cell during reset itself
// a result that is not taken holds the sequencer at its last step; the next
// item is accepted as soon as the sequencer is idle again
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator import ffla_pkg::*; #(
    parameter int unsigned MAX_ENTRIES = FFLA_MAX_ENTRIES
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [63:0]          s_tdata,   // block_addr, block_len
    input  wire logic                 s_tuser,   // func
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // grant_addr, grant_ok, free_total, entry_count, lost_blocks, lost_bytes
    output logic      [143:0]         m_tdata,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // ring of entry cells
    logic [31:0] cs [MAX_ENTRIES];
    logic [31:0] cl [MAX_ENTRIES];
    cell_ctl_t        ctl;
    logic [CNT_W-1:0] lim;

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            localparam int unsigned L = (g == 0) ? MAX_ENTRIES - 1 : g - 1;
            localparam int unsigned R = (g == MAX_ENTRIES - 1) ? 0 : g + 1;
            ffla_cell #(.MAX_ENTRIES(MAX_ENTRIES), .IDX(g)) u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .lim        (lim),
                .left_start (cs[L]),
                .left_len   (cl[L]),
                .right_start(cs[R]),
                .right_len  (cl[R]),
                .cell_start (cs[g]),
                .cell_len   (cl[g])
            );
        end
    endgenerate

    // sequencer state
    st_t              state_reg, state_next;
    logic [CNT_W-1:0] r_reg, r_next;          // ring offset = index at head
    logic [CNT_W-1:0] used_reg, used_next;
    logic [31:0]      free_reg, free_next;
    logic [31:0]      dcnt_reg, dcnt_next;
    logic [31:0]      dbytes_reg, dbytes_next;
    logic [31:0]      base_reg, base_next;
    logic             func_reg, func_next;
    logic [31:0]      addr_reg, addr_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      grant_reg, grant_next;
    logic             ok_reg, ok_next;
    logic             mval_reg, mval_next;
    logic [143:0]     mdata_reg, mdata_next;

    // head entry (index r) and the one before it (index r-1, last cell)
    logic [31:0] cur_start, cur_len, prv_start, prv_len;
    logic        has_cur, has_prv, lower, upper;

    assign cur_start = cs[0];
    assign cur_len   = cl[0];
    assign prv_start = cs[MAX_ENTRIES-1];
    assign prv_len   = cl[MAX_ENTRIES-1];
    assign has_cur   = r_reg < used_reg;
    assign has_prv   = r_reg != '0;
    assign lower     = has_prv && (prv_start + prv_len == addr_reg);
    assign upper     = has_cur && (addr_reg + len_reg == cur_start);

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;

    always_comb begin
        state_next  = state_reg;
        r_next      = r_reg;
        used_next   = used_reg;
        free_next   = free_reg;
        dcnt_next   = dcnt_reg;
        dbytes_next = dbytes_reg;
        base_next   = base_reg;
        func_next   = func_reg;
        addr_next   = addr_reg;
        len_next    = len_reg;
        grant_next  = grant_reg;
        ok_next     = ok_reg;
        mval_next   = mval_reg;
        mdata_next  = mdata_reg;
        ctl         = '0;
        lim         = used_reg - CNT_ONE - r_reg;

        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end

        // configuration: heap_end reloads the list as one region
        if (cfg_we && cfg_index == REG_HEAP_BASE) begin
            base_next = cfg_data;
        end
        if (cfg_we && cfg_index == REG_HEAP_END) begin
            ctl.wr0     = 1'b1;
            ctl.wstart  = base_reg;
            ctl.wlen    = cfg_data - base_reg;
            used_next   = CNT_ONE;
            free_next   = cfg_data - base_reg;
            dcnt_next   = '0;
            dbytes_next = '0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next  = s_tuser;
                    addr_next  = s_tdata[31:0];
                    len_next   = s_tdata[63:32];
                    grant_next = '0;
                    ok_next    = 1'b0;
                    r_next     = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (func_reg == FUNC_ALLOC) begin
                    if (!has_cur) begin
                        state_next = ST_REST;           // no entry large enough
                    end else if (cur_len >= len_reg) begin
                        grant_next = cur_start;
                        ok_next    = 1'b1;
                        free_next  = free_reg - len_reg;
                        if (cur_len == len_reg) begin
                            ctl.shl   = 1'b1;           // entry used up
                            used_next = used_reg - CNT_ONE;
                        end else begin
                            ctl.wr0    = 1'b1;
                            ctl.wstart = cur_start + len_reg;
                            ctl.wlen   = cur_len - len_reg;
                        end
                        state_next = ST_REST;
                    end else begin
                        ctl.rot = 1'b1;
                        r_next  = r_reg + CNT_ONE;
                    end
                end else begin
                    if (has_cur && cur_start <= addr_reg) begin
                        ctl.rot = 1'b1;
                        r_next  = r_reg + CNT_ONE;
                    end else begin
                        state_next = ST_REST;
                        if (lower) begin
                            // merge into lower neighbor, maybe absorb upper
                            ctl.wrl    = 1'b1;
                            ctl.wstart = prv_start;
                            ctl.wlen   = prv_len + len_reg + (upper ? cur_len : 32'd0);
                            ctl.shl    = upper;
                            if (upper) begin
                                used_next = used_reg - CNT_ONE;
                            end
                            free_next = free_reg + len_reg;
                            ok_next   = 1'b1;
                        end else if (upper) begin
                            ctl.wr0    = 1'b1;
                            ctl.wstart = addr_reg;
                            ctl.wlen   = cur_len + len_reg;
                            free_next  = free_reg + len_reg;
                            ok_next    = 1'b1;
                        end else if (used_reg < CNT_MAX) begin
                            // new entry at the head, later entries move up
                            lim        = used_reg - r_reg;
                            ctl.shr    = 1'b1;
                            ctl.wr0    = 1'b1;
                            ctl.wstart = addr_reg;
                            ctl.wlen   = len_reg;
                            used_next  = used_reg + CNT_ONE;
                            free_next  = free_reg + len_reg;
                            ok_next    = 1'b1;
                            if (dcnt_reg != '0) begin
                                dcnt_next   = dcnt_reg - 32'd1;
                                dbytes_next = dbytes_reg - len_reg;
                            end
                        end else begin
                            // list full: block is lost
                            dcnt_next   = dcnt_reg + 32'd1;
                            dbytes_next = dbytes_reg + len_reg;
                        end
                    end
                end
            end
            ST_REST: begin
                if (r_reg == CNT_MAX) begin
                    if (!mval_reg || m_tready) begin
                        mval_next  = 1'b1;
                        mdata_next = {4'd0, dbytes_reg, dcnt_reg, 11'(used_reg),
                                      free_reg, ok_reg, grant_reg};
                        state_next = ST_IDLE;
                    end
                end else begin
                    ctl.rot = 1'b1;
                    r_next  = r_reg + CNT_ONE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // reset writes the initial (0, 0) entry
        if (!aresetn) begin
            ctl        = '0;
            ctl.wr0    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            used_reg   <= CNT_ONE;
            free_reg   <= '0;
            dcnt_reg   <= '0;
            dbytes_reg <= '0;
            base_reg   <= '0;
            mval_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            free_reg   <= free_next;
            dcnt_reg   <= dcnt_next;
            dbytes_reg <= dbytes_next;
            base_reg   <= base_next;
            mval_reg   <= mval_next;
        end
        r_reg     <= r_next;
        func_reg  <= func_next;
        addr_reg  <= addr_next;
        len_reg   <= len_next;
        grant_reg <= grant_next;
        ok_reg    <= ok_next;
        mdata_reg <= mdata_next;
    end

    // list never grows past its capacity
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_MAX)
        else $error("entry count beyond capacity");

    // an accepted item always starts a ring walk
    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_SCAN && r_reg == '0))
        else $error("accepted item did not start scan");

    // the ring offset never passes a full turn while walking
    a_rot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REST || state_reg == ST_SCAN) |-> r_reg <= CNT_MAX)
        else $error("ring offset past a full turn");

endmodule
`default_nettype wire

/* hdl/ffla_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffla_cell - one free-list entry of the ring
// Holds a start/length pair; takes its neighbor's pair on rotate or shift, or wstart/wlen on a write.
// ----------------------------------------------------------------------------
module ffla_cell import ffla_pkg::*; #(
    parameter int unsigned MAX_ENTRIES = FFLA_MAX_ENTRIES,
    parameter int unsigned IDX         = 0,
    localparam int unsigned CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic             aclk,
    input  wire cell_ctl_t        ctl,
    input  wire logic [CNT_W-1:0] lim,
    input  wire logic [31:0]      left_start,
    input  wire logic [31:0]      left_len,
    input  wire logic [31:0]      right_start,
    input  wire logic [31:0]      right_len,
    output logic      [31:0]      cell_start,
    output logic      [31:0]      cell_len
);

    localparam logic [CNT_W-1:0] POS = CNT_W'(IDX);

    logic [31:0] start_reg, start_next;
    logic [31:0] len_reg, len_next;

    always_comb begin
        start_next = start_reg;
        len_next   = len_reg;
        if (ctl.rot || (ctl.shl && POS < lim)) begin
            start_next = right_start;
            len_next   = right_len;
        end else if (ctl.shr && IDX != 0 && POS <= lim) begin
            start_next = left_start;
            len_next   = left_len;
        end else if ((ctl.wr0 && IDX == 0) || (ctl.wrl && IDX == MAX_ENTRIES - 1)) begin
            start_next = ctl.wstart;
            len_next   = ctl.wlen;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg <= start_next;
        len_reg   <= len_next;
    end

    assign cell_start = start_reg;
    assign cell_len   = len_reg;

endmodule
`default_nettype wire

/* tb/first_fit_free_list_allocator_test.sv */
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_test - self-checking bench of the allocator
// Drives allocate and release items with random idling on both sides, keeps
// its own copy of the address-sorted free list and checks every result.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_test;
    import ffla_pkg::*;

    localparam int unsigned DEPTH      = FFLA_MAX_ENTRIES;
    localparam int unsigned IDLE_LIMIT = 20000;

    // expected result of one item, last field in the lowest bits
    typedef struct packed {
        logic [31:0] lost_bytes;
        logic [31:0] lost_blocks;
        logic [10:0] entry_count;
        logic [31:0] free_total;
        logic        grant_ok;
        logic [31:0] grant_addr;
    } grant_t;

    // free-list predictor and queue of pending grants
    class alloc_scoreboard;
        logic [31:0] base_reg, end_reg;
        logic [31:0] fl_start[DEPTH];
        logic [31:0] fl_len[DEPTH];
        int unsigned fl_used;
        logic [31:0] fl_sum, lost_cnt, lost_sum;
        grant_t      pending[$];
        int          mismatches;
        int          checked;

        function void reload();
            fl_start[0] = base_reg;
            fl_len[0]   = end_reg - base_reg;
            fl_used     = 1;
            fl_sum      = fl_len[0];
            lost_cnt    = 0;
            lost_sum    = 0;
        endfunction

        function void drop_entry(int unsigned k);
            fl_used--;
            for (int unsigned j = k; j < fl_used; j++) begin
                fl_start[j] = fl_start[j+1];
                fl_len[j]   = fl_len[j+1];
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            if (idx == REG_HEAP_BASE) base_reg = val;
            else if (idx == REG_HEAP_END) begin
                end_reg = val;
                reload();
            end
        endfunction

        // predict the grant of one accepted item
        function void note_item(logic func, logic [31:0] addr, logic [31:0] len);
            grant_t      g;
            int unsigned k;
            g = '0;
            if (func == FUNC_ALLOC) begin
                for (k = 0; k < fl_used; k++) begin
                    if (fl_len[k] >= len) begin
                        g.grant_addr = fl_start[k];
                        g.grant_ok   = 1'b1;
                        fl_start[k] += len;
                        fl_len[k]   -= len;
                        fl_sum      -= len;
                        if (fl_len[k] == 0) drop_entry(k);
                        break;
                    end
                end
            end else begin
                for (k = 0; k < fl_used; k++)
                    if (fl_start[k] > addr) break;
                g.grant_ok = 1'b1;
                if (k > 0 && fl_start[k-1] + fl_len[k-1] == addr) begin
                    fl_len[k-1] += len;
                    fl_sum      += len;
                    if (k < fl_used && addr + len == fl_start[k]) begin
                        fl_len[k-1] += fl_len[k];
                        drop_entry(k);
                    end
                end else if (k < fl_used && addr + len == fl_start[k]) begin
                    fl_start[k] = addr;
                    fl_len[k]  += len;
                    fl_sum     += len;
                end else if (fl_used < DEPTH) begin
                    for (int unsigned j = fl_used; j > k; j--) begin
                        fl_start[j] = fl_start[j-1];
                        fl_len[j]   = fl_len[j-1];
                    end
                    fl_used++;
                    if (lost_cnt > 0) begin
                        lost_cnt--;
                        lost_sum -= len;
                    end
                    fl_start[k] = addr;
                    fl_len[k]   = len;
                    fl_sum     += len;
                end else begin
                    lost_cnt++;
                    lost_sum  += len;
                    g.grant_ok = 1'b0;
                end
            end
            g.free_total  = fl_sum;
            g.entry_count = 11'(fl_used);
            g.lost_blocks = lost_cnt;
            g.lost_bytes  = lost_sum;
            pending.push_back(g);
        endfunction

        function void check_grant(grant_t got);
            grant_t want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch on result %0d", checked);
                    $display("  addr %h/%h ok %b/%b free %h/%h",
                        want.grant_addr, got.grant_addr, want.grant_ok, got.grant_ok,
                        want.free_total, got.free_total);
                    $display("  count %0d/%0d lost %h/%h bytes %h/%h",
                        want.entry_count, got.entry_count, want.lost_blocks,
                        got.lost_blocks, want.lost_bytes, got.lost_bytes);
                end
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata = '0;   // block_addr, block_len
    logic                 s_tuser = 1'b0; // func
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // grant_addr, grant_ok, free_total, entry_count, lost_blocks, lost_bytes
    logic [143:0]         m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    alloc_scoreboard sb;
    bit              calm;        // no idling in this stretch
    int              idle_cycles;
    int              items_sent;
    int              releases_sent;

    always #10 aclk = ~aclk;

    first_fit_free_list_allocator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // result side: random stalls, check on each accepted result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_grant(grant_t'(m_tdata[139:0]));
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // one write per call
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // send one item, holding it until the handshake
    task automatic send_item(logic func, logic [31:0] addr, logic [31:0] len);
        @(posedge aclk);
        if (!calm)
            while ($urandom_range(99) < 23) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {len, addr};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(func, addr, len);
        s_tvalid <= 1'b0;
        items_sent++;
        if (func == FUNC_RELEASE) releases_sent++;
    endtask

    // wait for all results, then let the sequencer settle
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DEPTH + 8) @(posedge aclk);
    endtask

    // load a region: base then end, which reloads the list
    task automatic load_heap(logic [31:0] b, logic [31:0] e);
        drain();
        write_reg(REG_HEAP_BASE, b);
        write_reg(REG_HEAP_END, e);
    endtask

    // random phase over a region; mostly sized requests and frees of earlier grants
    task automatic random_phase(int n, logic [31:0] b, logic [31:0] span);
        logic [31:0] granted[$];
        logic [31:0] sizes[$];
        logic [31:0] a, l;
        int          pick;
        for (int i = 0; i < n; i++) begin
            if (i == n / 3) calm = 1'b1;
            if (i == n / 2) calm = 1'b0;
            pick = $urandom_range(99);
            if (pick < 45) begin
                l = $urandom_range(64);
                if (pick < 3) l = $urandom;
                send_item(FUNC_ALLOC, $urandom, l);
                if (sb.pending[$].grant_ok) begin
                    granted.push_back(sb.pending[$].grant_addr);
                    sizes.push_back(l);
                end
            end else if (pick < 85 && granted.size() > 0) begin
                pick = $urandom_range(granted.size() - 1);
                a = granted[pick];
                l = sizes[pick];
                granted.delete(pick);
                sizes.delete(pick);
                send_item(FUNC_RELEASE, a, l);
            end else begin
                // scattered frees, just past the region end or at random addresses
                a = b + span + $urandom_range(1, 4000);
                if ($urandom_range(3) == 0) a = $urandom;
                send_item(FUNC_RELEASE, a, $urandom_range(1, 16));
            end
        end
    endtask

    initial begin
        sb = new();
        sb.base_reg = '0;
        sb.end_reg  = '0;
        sb.reload();
        calm = 1'b0;
        items_sent = 0;
        releases_sent = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset list holds one empty entry at zero
        send_item(FUNC_ALLOC, '0, '0);          // zero length takes and removes it
        send_item(FUNC_ALLOC, '1, 32'd1);       // empty list fails
        send_item(FUNC_RELEASE, '1, '1);        // insert at extremes
        send_item(FUNC_ALLOC, '0, '1);
        load_heap(32'h0000_1000, 32'h0000_2000);
        send_item(FUNC_ALLOC, '0, 32'd256);
        send_item(FUNC_ALLOC, '0, 32'd256);
        send_item(FUNC_ALLOC, '0, 32'h0001_0000); // too big
        send_item(FUNC_RELEASE, 32'h0000_1000, 32'd256);  // into gap below
        send_item(FUNC_RELEASE, 32'h0000_1100, 32'd256);  // merges both sides
        send_item(FUNC_RELEASE, 32'h0000_3000, 32'd16);   // plain insert
        send_item(FUNC_RELEASE, 32'h0000_2000, 32'd16);   // merge below
        send_item(FUNC_RELEASE, 32'h0000_0ff0, 32'd16);   // merge above
        send_item(FUNC_RELEASE, 32'h0000_0000, 32'd1);
        send_item(FUNC_ALLOC, '0, 32'd0);
        // end below base wraps the length
        load_heap(32'hffff_ff00, 32'h0000_0100);
        send_item(FUNC_ALLOC, '0, 32'h0000_0180);
        send_item(FUNC_RELEASE, 32'hffff_ff00, 32'h0000_0180); // wraps through zero
        load_heap('1, '1);
        send_item(FUNC_ALLOC, '0, '0);

        load_heap(32'h0004_0000, 32'h0004_4000);
        random_phase(140, 32'h0004_0000, 32'h4000);
        load_heap($urandom, $urandom);
        random_phase(130, sb.base_reg, sb.end_reg - sb.base_reg);

        drain();
        $display("ran %0d items (%0d releases) over five heap settings, %0d results",
            items_sent, releases_sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("FAILURE");
        end
        $finish;
    end
endmodule

/* first_fit_free_list_allocator.f */
hdl/ffla_pkg.sv
hdl/ffla_cell.sv
hdl/first_fit_free_list_allocator.sv
tb/first_fit_free_list_allocator_test.sv
